[rtl/core/sbpe_pkg.sv]
// ============================================================================
// sbpe_pkg: shared types and constants of the six-bit printable encoder
// Word formats of both channels, the group phase codes and the record that
// the encoder logic hands to the result buffer.
// ============================================================================
package sbpe_pkg;

    // Printable base that is ORed onto every 6-bit value.
    localparam logic [6:0] CHAR_BASE = 7'h40;

    // Position of the next byte within its three-byte group.
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } phase_t;

    // One raw byte of the message.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_word_t;

    // One printable character.
    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } out_word_t;

    // What one byte produces, and the state it leaves behind.
    typedef struct packed {
        out_word_t  first;
        out_word_t  second;
        logic       two_chars;
        phase_t     next_phase;
        logic [5:0] next_carry;
    } enc_result_t;

endpackage

[rtl/core/sbpe_encode.sv]
// ============================================================================
// sbpe_encode: character generation for one raw byte
// Splits the byte against the pending carry bits according to the group
// phase, and adds a zero-filled flush character if a message ends mid-group.
// ============================================================================
module sbpe_encode (
    input  sbpe_pkg::in_word_t    in_word,
    input  sbpe_pkg::phase_t      phase,
    input  logic [5:0]            carry,
    output sbpe_pkg::enc_result_t result
);

    logic [7:0]       b;
    logic [5:0]       value0;
    logic [5:0]       value1;
    logic [5:0]       carry_step;
    logic             two_step;
    sbpe_pkg::phase_t phase_step;

    assign b = in_word.data_byte;

    // Split the byte by group phase; an unused phase code starts a new group.
    always_comb begin
        value1 = b[5:0];
        case (phase)
            sbpe_pkg::PHASE_SECOND: begin
                value0     = carry | {2'b00, b[7:4]};
                carry_step = {b[3:0], 2'b00};
                phase_step = sbpe_pkg::PHASE_THIRD;
                two_step   = 1'b0;
            end
            sbpe_pkg::PHASE_THIRD: begin
                value0     = carry | {4'b0000, b[7:6]};
                carry_step = 6'd0;
                phase_step = sbpe_pkg::PHASE_FIRST;
                two_step   = 1'b1;
            end
            default: begin
                value0     = b[7:2];
                carry_step = {b[1:0], 4'b0000};
                phase_step = sbpe_pkg::PHASE_SECOND;
                two_step   = 1'b0;
            end
        endcase
    end

    // At the end of a message the pending bits go out and the state clears.
    always_comb begin
        result.first.out_char  = sbpe_pkg::CHAR_BASE | {1'b0, value0};
        result.second.last_char = 1'b1;
        if (in_word.end_of_message) begin
            result.second.out_char = sbpe_pkg::CHAR_BASE |
                                     {1'b0, (two_step ? value1 : carry_step)};
            result.two_chars       = 1'b1;
            result.next_phase      = sbpe_pkg::PHASE_FIRST;
            result.next_carry      = 6'd0;
        end else begin
            result.second.out_char = sbpe_pkg::CHAR_BASE | {1'b0, value1};
            result.two_chars       = two_step;
            result.next_phase      = phase_step;
            result.next_carry      = carry_step;
        end
        result.first.last_char = !result.two_chars;
    end

endmodule

[rtl/core/six_bit_printable_encoder.sv]
// ============================================================================
// six_bit_printable_encoder: raw bytes to printable six-bit characters
// Every three bytes become four characters of 0x40 ORed with a 6-bit value;
// the final byte of a message flushes pending bits with zero fill.
// ============================================================================
//
//  Channel | Ports                      | Word
//  --------+----------------------------+-------------------------------------
//  input   | s_valid, s_ready, s_data   | data_byte, end_of_message
//  result  | m_valid, m_ready, m_data   | out_char, last_char
//
//  A byte is registered on acceptance and encoded on its way into a
//  two-slot result buffer, which presents one character per cycle
//  while m_ready is high. A byte that yields one character sustains
//  one byte per cycle likewise; a byte that yields two (third of a
//  group, or end of message) holds the next byte back until its second
//  character leaves. Reset clears the group phase, carry bits and all
//  valid flags. A stalled result channel holds the buffer; the input
//  register keeps accepting until it too is full.
//
module six_bit_printable_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sbpe_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sbpe_pkg::out_word_t  m_data
);

    sbpe_pkg::in_word_t    in_word_reg;
    logic                  in_valid_reg;
    sbpe_pkg::phase_t      phase_reg;
    logic [5:0]            carry_reg;
    sbpe_pkg::out_word_t   slot0_reg;
    sbpe_pkg::out_word_t   slot1_reg;
    logic [1:0]            count_reg;
    sbpe_pkg::enc_result_t enc;
    logic                  pop;
    logic                  xfer;

    // Encoder between the input register and the result buffer.
    sbpe_encode u_encode (
        .in_word (in_word_reg),
        .phase   (phase_reg),
        .carry   (carry_reg),
        .result  (enc)
    );

    // Handshake: the buffer takes a new byte once it is empty or drains now.
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot0_reg;
    assign pop     = m_valid && m_ready;
    assign xfer    = in_valid_reg &&
                     ((count_reg == 2'd0) || ((count_reg == 2'd1) && m_ready));
    assign s_ready = !in_valid_reg || xfer;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    // Group state advances when a byte moves into the result buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sbpe_pkg::PHASE_FIRST;
            carry_reg <= 6'd0;
        end else if (xfer) begin
            phase_reg <= enc.next_phase;
            carry_reg <= enc.next_carry;
        end
    end

    // Result buffer: loads one or two characters, shifts out one per pop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (xfer) begin
            count_reg <= enc.two_chars ? 2'd2 : 2'd1;
        end else if (pop) begin
            count_reg <= count_reg - 2'd1;
        end
        if (xfer) begin
            slot0_reg <= enc.first;
            slot1_reg <= enc.second;
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

    // The buffer never holds more than the two characters of one byte.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg != 2'd3)
        else $error("result buffer count out of range");

    // The phase code left unused by the encoder never appears.
    assert property (@(posedge aclk) disable iff (!aresetn) phase_reg != 2'd3)
        else $error("group phase reached unused code");

    // A lone remaining character closes its byte; the first of two does not.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd1) |-> slot0_reg.last_char)
        else $error("final buffered character not marked last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'd2) |-> !slot0_reg.last_char)
        else $error("first of two characters marked last");

    // The end of a message always returns the group to its start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer && in_word_reg.end_of_message) |=>
            (phase_reg == sbpe_pkg::PHASE_FIRST) && (carry_reg == 6'd0))
        else $error("group state not cleared after end of message");

endmodule
